/* rtl/uvs_pkg.sv */
// Package for the UV sphere vertex generator.
// Holds the fixed-point constants, the arctangent table, the queue item types
// and the rounding helper. It depends on nothing.
package uvs_pkg;

	localparam int FRAC_BITS = 15;
	localparam logic [7:0] MAX_SUBDIV = 8'd255;
	localparam logic [7:0] SUBDIV_RESET = 8'd16;

	localparam int QW = 34;
	localparam int DIV_LAT = QW;
	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_LAT = CORDIC_STEPS + 2;
	localparam int XW = 34;
	localparam logic signed [XW-1:0] CORDIC_ONE = 34'sd652032874;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
		32'd20, 32'd10, 32'd5, 32'd3, 32'd1
	};

	typedef struct packed {
		logic        oor;
		logic        quad;
		logic [15:0] idx;
		logic [15:0] ca;
		logic [15:0] cb;
		logic [15:0] cc;
		logic [15:0] cd;
	} uvs_side_t;

	typedef struct packed {
		logic [7:0] ring;
		logic [7:0] seg;
		logic [7:0] p;
		uvs_side_t  side;
	} uvs_item_t;

	// Rounds half up with an arithmetic shift, then saturates to Q1.FRAC_BITS.
	function automatic logic [15:0] rnd_sat(input logic signed [65:0] v, input int sh);
		logic signed [65:0] r;
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		logic [15:0] res;
		begin
			hi = (66'sd1 <<< FRAC_BITS) - 66'sd1;
			lo = -(66'sd1 <<< FRAC_BITS);
			if (sh == 0) begin
				r = v;
			end else begin
				r = (v + (66'sd1 <<< (sh - 1))) >>> sh;
			end
			if (r > hi) begin
				res = hi[15:0];
			end else if (r < lo) begin
				res = lo[15:0];
			end else begin
				res = r[15:0];
			end
			return res;
		end
	endfunction

endpackage

/* rtl/uvs_if.sv */
// Channel interfaces of the UV sphere vertex generator.
// Grid point input, vertex output and subdivision configuration write.
// Depends on nothing.
interface uvs_pt_if;
	logic       valid;
	logic       ready;
	logic [7:0] ring;
	logic [7:0] segment;
	modport source(output valid, ring, segment, input ready);
	modport sink(input valid, ring, segment, output ready);
endinterface

interface uvs_vtx_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] pos_z;
	logic [15:0]        tex_u;
	logic [15:0]        tex_v;
	logic [15:0]        vertex_index;
	logic               quad_valid;
	logic [15:0]        corner_a;
	logic [15:0]        corner_b;
	logic [15:0]        corner_c;
	logic [15:0]        corner_d;
	logic               out_of_range;
	modport source(output valid, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_index,
		quad_valid, corner_a, corner_b, corner_c, corner_d, out_of_range, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_index,
		quad_valid, corner_a, corner_b, corner_c, corner_d, out_of_range, output ready);
endinterface

interface uvs_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] subdivisions;
	modport source(output valid, subdivisions, input ready);
	modport sink(input valid, subdivisions, output ready);
endinterface

/* rtl/uv_sphere_vertex_generator_unit.sv */
// Top level of the UV sphere vertex generator: front end, queue and back end.
// Depends on uvs_pkg, uvs_if, uvs_front, uvs_queue and uvs_back.
//
//   channel  role    word
//   pt       sink    ring, segment of one grid point
//   vtx      source  position, texture, vertex index, quad corners, range flag
//   cfg      sink    subdivisions, always ready
//
// One grid point is accepted every cycle while the queue is not full. Its word passes
// through the front register, the queue memory, the 34-stage divider, the 32-stage
// CORDIC pipeline and two product and rounding stages.
// Reset clears all valid state and sets subdivisions to 16.
// A stalled vertex output holds the back end, while the queue lets the front end
// keep accepting up to its depth.
module uv_sphere_vertex_generator_unit (
	input  logic     clk,
	input  logic     arst_n,
	uvs_pt_if.sink   pt,
	uvs_vtx_if.source vtx,
	uvs_cfg_if.sink  cfg
);
	import uvs_pkg::*;

	uvs_item_t fr_item;
	logic      fr_vld;
	logic      fr_rdy;
	uvs_item_t bk_item;
	logic      bk_vld;
	logic      bk_pop;

	uvs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt       (pt),
		.cfg      (cfg),
		.item     (fr_item),
		.item_vld (fr_vld),
		.item_rdy (fr_rdy)
	);

	uvs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_item (fr_item),
		.wr_vld  (fr_vld),
		.wr_rdy  (fr_rdy),
		.rd_item (bk_item),
		.rd_vld  (bk_vld),
		.rd_pop  (bk_pop)
	);

	uvs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (bk_item),
		.item_vld (bk_vld),
		.item_pop (bk_pop),
		.vtx      (vtx)
	);

endmodule

/* rtl/uvs_front.sv */
// Front end: holds the subdivision register, accepts grid points, classifies them
// and computes the vertex and quad corner indices.
// Depends on uvs_pkg and uvs_if.
module uvs_front (
	input  logic              clk,
	input  logic              arst_n,
	uvs_pt_if.sink            pt,
	uvs_cfg_if.sink           cfg,
	output uvs_pkg::uvs_item_t item,
	output logic              item_vld,
	input  logic              item_rdy
);
	import uvs_pkg::*;

	logic [7:0]  subdiv_q;
	logic [7:0]  p;
	logic        oor;
	logic        quad;
	logic [16:0] idx_full;
	logic [15:0] idx;
	uvs_item_t   nxt;
	uvs_item_t   item_s1;
	logic        vld_s1;
	logic        acc;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subdiv_q <= SUBDIV_RESET;
		end else if (cfg.valid) begin
			subdiv_q <= cfg.subdivisions;
		end
	end

	always_comb begin
		p = subdiv_q;
		if (p == 8'd0) begin
			p = 8'd1;
		end
		if (p > MAX_SUBDIV) begin
			p = MAX_SUBDIV;
		end
		oor = (pt.ring > p) || (pt.segment > p);
		quad = !oor && (pt.ring < p) && (pt.segment < p);
		idx_full = {9'd0, pt.ring} * ({9'd0, p} + 17'd1) + {9'd0, pt.segment};
		idx = idx_full[15:0];
		nxt = '0;
		nxt.ring = pt.ring;
		nxt.seg = pt.segment;
		nxt.p = p;
		nxt.side.oor = oor;
		if (!oor) begin
			nxt.side.idx = idx;
		end
		if (quad) begin
			nxt.side.quad = 1'b1;
			nxt.side.ca = idx;
			nxt.side.cb = idx + 16'd1;
			nxt.side.cc = idx + {8'd0, p} + 16'd1;
			nxt.side.cd = idx + {8'd0, p} + 16'd2;
		end
	end

	assign pt.ready = !vld_s1 || item_rdy;
	assign acc = pt.valid && pt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (acc) begin
			vld_s1 <= 1'b1;
		end else if (item_rdy) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1 <= nxt;
		end
	end

	assign item = item_s1;
	assign item_vld = vld_s1;

endmodule

/* rtl/uvs_queue.sv */
// Short queue between the front end and the back end.
// Depends on uvs_pkg.
module uvs_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  uvs_pkg::uvs_item_t wr_item,
	input  logic              wr_vld,
	output logic              wr_rdy,
	output uvs_pkg::uvs_item_t rd_item,
	output logic              rd_vld,
	input  logic              rd_pop
);
	import uvs_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	uvs_item_t     mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   cnt_q;
	logic          push;
	logic          pop;

	assign wr_rdy = (cnt_q != QUEUE_DEPTH[PW:0]);
	assign rd_vld = (cnt_q != '0);
	assign push = wr_vld && wr_rdy;
	assign pop = rd_pop && rd_vld;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

/* rtl/uvs_div.sv */
// Two-lane pipelined restoring divider giving floor(a * 2^33 / p) for a below 2p, one
// quotient bit per stage, with a tag carried alongside.
// Depends on uvs_pkg.
module uvs_div #(
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [7:0]       a [2],
	input  logic [7:0]       p,
	input  logic [TAG_W-1:0] tag_in,
	output logic             out_vld,
	output logic [uvs_pkg::QW-1:0] q [2],
	output logic [TAG_W-1:0] tag_out
);
	import uvs_pkg::*;

	logic               vld_s [DIV_LAT];
	logic [7:0]         rem_s [2][DIV_LAT];
	logic [QW-1:0]      quo_s [2][DIV_LAT];
	logic [7:0]         p_s [DIV_LAT];
	logic [TAG_W-1:0]   tag_s [DIV_LAT];

	for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
		logic [8:0]    trial [2];
		logic [8:0]    diff [2];
		logic [QW-1:0] qprev [2];
		logic [7:0]    pin;
		logic          vin;
		logic [TAG_W-1:0] tin;

		always_comb begin
			if (k == 0) begin
				pin = p;
				vin = in_vld;
				tin = tag_in;
			end else begin
				pin = p_s[(k == 0) ? 0 : k - 1];
				vin = vld_s[(k == 0) ? 0 : k - 1];
				tin = tag_s[(k == 0) ? 0 : k - 1];
			end
			for (int l = 0; l < 2; l++) begin
				if (k == 0) begin
					trial[l] = {1'b0, a[l]};
					qprev[l] = '0;
				end else begin
					trial[l] = {rem_s[l][(k == 0) ? 0 : k - 1], 1'b0};
					qprev[l] = quo_s[l][(k == 0) ? 0 : k - 1];
				end
				diff[l] = trial[l] - {1'b0, pin};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				p_s[k] <= pin;
				tag_s[k] <= tin;
				for (int l = 0; l < 2; l++) begin
					if (trial[l] >= {1'b0, pin}) begin
						rem_s[l][k] <= diff[l][7:0];
						quo_s[l][k] <= {qprev[l][QW-2:0], 1'b1};
					end else begin
						rem_s[l][k] <= trial[l][7:0];
						quo_s[l][k] <= {qprev[l][QW-2:0], 1'b0};
					end
				end
			end
		end
	end

	assign out_vld = vld_s[DIV_LAT-1];
	assign q[0] = quo_s[0][DIV_LAT-1];
	assign q[1] = quo_s[1][DIV_LAT-1];
	assign tag_out = tag_s[DIV_LAT-1];

endmodule

/* rtl/uvs_cordic.sv */
// Two-lane unrolled rotation-mode CORDIC giving cosine and sine in Q2.30 of
// phases in units of 2^-32 turn, with a tag carried alongside.
// Depends on uvs_pkg.
module uvs_cordic #(
	parameter int TAG_W = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic [31:0]        ph [2],
	input  logic [TAG_W-1:0]   tag_in,
	output logic               out_vld,
	output logic signed [31:0] cosv [2],
	output logic signed [31:0] sinv [2],
	output logic [TAG_W-1:0]   tag_out
);
	import uvs_pkg::*;

	logic [CORDIC_STEPS:0]   vld_s;
	logic signed [XW-1:0]    x_s [2][CORDIC_STEPS+1];
	logic signed [XW-1:0]    y_s [2][CORDIC_STEPS+1];
	logic signed [XW-1:0]    z_s [2][CORDIC_STEPS+1];
	logic                    flip_s [2][CORDIC_STEPS+1];
	logic [TAG_W-1:0]        tag_s [CORDIC_STEPS+1];
	logic                    vld_o;
	logic signed [31:0]      cos_o [2];
	logic signed [31:0]      sin_o [2];
	logic [TAG_W-1:0]        tag_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			vld_o <= 1'b0;
		end else if (en) begin
			vld_s <= {vld_s[CORDIC_STEPS-1:0], in_vld};
			vld_o <= vld_s[CORDIC_STEPS];
		end
	end

	// A phase in the left half plane is turned by half a turn and negated at the end.
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= tag_in;
			for (int l = 0; l < 2; l++) begin
				flip_s[l][0] <= ph[l][31] ^ ph[l][30];
				x_s[l][0] <= CORDIC_ONE;
				y_s[l][0] <= '0;
				z_s[l][0] <= XW'($signed({ph[l][30], ph[l][30:0]}));
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [XW-1:0] ang;
		assign ang = $signed({{(XW-32){1'b0}}, ATAN_TURNS[i]});

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[i+1] <= tag_s[i];
				for (int l = 0; l < 2; l++) begin
					flip_s[l][i+1] <= flip_s[l][i];
					if (!z_s[l][i][XW-1]) begin
						x_s[l][i+1] <= x_s[l][i] - (y_s[l][i] >>> i);
						y_s[l][i+1] <= y_s[l][i] + (x_s[l][i] >>> i);
						z_s[l][i+1] <= z_s[l][i] - ang;
					end else begin
						x_s[l][i+1] <= x_s[l][i] + (y_s[l][i] >>> i);
						y_s[l][i+1] <= y_s[l][i] - (x_s[l][i] >>> i);
						z_s[l][i+1] <= z_s[l][i] + ang;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_o <= tag_s[CORDIC_STEPS];
			for (int l = 0; l < 2; l++) begin
				if (flip_s[l][CORDIC_STEPS]) begin
					cos_o[l] <= 32'(-x_s[l][CORDIC_STEPS]);
					sin_o[l] <= 32'(-y_s[l][CORDIC_STEPS]);
				end else begin
					cos_o[l] <= x_s[l][CORDIC_STEPS][31:0];
					sin_o[l] <= y_s[l][CORDIC_STEPS][31:0];
				end
			end
		end
	end

	assign out_vld = vld_o;
	assign cosv = cos_o;
	assign sinv = sin_o;
	assign tag_out = tag_o;

endmodule

/* rtl/uvs_back.sv */
// Back end: angle and texture division, CORDIC, products, rounding and the
// output register. Depends on uvs_pkg, uvs_if, uvs_div and uvs_cordic.
module uvs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  uvs_pkg::uvs_item_t item,
	input  logic              item_vld,
	output logic              item_pop,
	uvs_vtx_if.source         vtx
);
	import uvs_pkg::*;

	typedef struct packed {
		uvs_side_t   side;
		logic [15:0] tu;
		logic [15:0] tv;
	} uvs_ctag_t;

	localparam int SIDE_W = $bits(uvs_side_t);
	localparam int CTAG_W = $bits(uvs_ctag_t);

	logic               en;
	logic [7:0]         div_a [2];
	logic               div_vld;
	logic [QW-1:0]      div_q [2];
	logic [SIDE_W-1:0]  div_tag;
	logic [QW:0]        t_ph_t;
	logic [QW:0]        t_ph_p;
	logic [QW:0]        t_tu;
	logic [QW:0]        t_tv;
	logic [31:0]        ph [2];
	uvs_ctag_t          ctag_in;
	logic [CTAG_W-1:0]  ctag_out;
	uvs_ctag_t          ctag;
	logic               cor_vld;
	logic signed [31:0] cosv [2];
	logic signed [31:0] sinv [2];

	logic               vld_s1;
	logic signed [63:0] px_s1;
	logic signed [63:0] pz_s1;
	logic signed [32:0] ny_s1;
	uvs_ctag_t          tag_s1;

	logic               vld_q;
	logic [15:0]        px_q;
	logic [15:0]        py_q;
	logic [15:0]        pz_q;
	logic [15:0]        tu_q;
	logic [15:0]        tv_q;
	uvs_side_t          side_q;

	assign en = !vld_q || vtx.ready;
	assign item_pop = en && item_vld;
	assign div_a[0] = item.ring;
	assign div_a[1] = item.seg;

	uvs_div #(.TAG_W(SIDE_W)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (item_pop),
		.a       (div_a),
		.p       (item.p),
		.tag_in  (item.side),
		.out_vld (div_vld),
		.q       (div_q),
		.tag_out (div_tag)
	);

	// Half-up rounding of the quotients into phases and texture coordinates.
	always_comb begin
		t_ph_t = ({1'b0, div_q[0]} >> 1) + 35'd1;
		t_ph_p = {1'b0, div_q[1]} + 35'd1;
		t_tu = ({1'b0, div_q[0]} >> (32 - FRAC_BITS)) + 35'd1;
		t_tv = ({1'b0, div_q[1]} >> (32 - FRAC_BITS)) + 35'd1;
		ph[0] = t_ph_t[32:1];
		ph[1] = t_ph_p[32:1];
		ctag_in.side = uvs_side_t'(div_tag);
		ctag_in.tu = t_tu[16:1];
		ctag_in.tv = t_tv[16:1];
	end

	uvs_cordic #(.TAG_W(CTAG_W)) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (div_vld),
		.ph      (ph),
		.tag_in  (ctag_in),
		.out_vld (cor_vld),
		.cosv    (cosv),
		.sinv    (sinv),
		.tag_out (ctag_out)
	);

	assign ctag = uvs_ctag_t'(ctag_out);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= cor_vld;
			vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= 64'(cosv[1]) * 64'(sinv[0]);
			pz_s1 <= 64'(sinv[1]) * 64'(sinv[0]);
			ny_s1 <= -33'(cosv[0]);
			tag_s1 <= ctag;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= tag_s1.side;
			if (tag_s1.side.oor) begin
				px_q <= '0;
				py_q <= '0;
				pz_q <= '0;
				tu_q <= '0;
				tv_q <= '0;
			end else begin
				px_q <= rnd_sat(-66'(px_s1), 60 - FRAC_BITS);
				py_q <= rnd_sat(66'(ny_s1), 30 - FRAC_BITS);
				pz_q <= rnd_sat(66'(pz_s1), 60 - FRAC_BITS);
				tu_q <= tag_s1.tu;
				tv_q <= tag_s1.tv;
			end
		end
	end

	assign vtx.valid = vld_q;
	assign vtx.pos_x = px_q;
	assign vtx.pos_y = py_q;
	assign vtx.pos_z = pz_q;
	assign vtx.tex_u = tu_q;
	assign vtx.tex_v = tv_q;
	assign vtx.vertex_index = side_q.idx;
	assign vtx.quad_valid = side_q.quad;
	assign vtx.corner_a = side_q.ca;
	assign vtx.corner_b = side_q.cb;
	assign vtx.corner_c = side_q.cc;
	assign vtx.corner_d = side_q.cd;
	assign vtx.out_of_range = side_q.oor;

endmodule

/* rtl/uvs_chk.sv */
// Port checker for the UV sphere vertex generator and its bind statement.
// Depends on the top level's port list.
module uvs_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [15:0] pos_x,
	input logic [15:0] vertex_index,
	input logic        quad_valid,
	input logic [15:0] corner_a,
	input logic [15:0] corner_b,
	input logic [15:0] corner_d,
	input logic        out_of_range
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("Vertex word dropped while stalled.");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> $stable(vertex_index) && $stable(pos_x))
		else $error("Vertex word changed while stalled.");

	a_oor: assert property (@(posedge clk) disable iff (!arst_n)
		valid && out_of_range |-> !quad_valid && vertex_index == 16'd0 && pos_x == 16'd0)
		else $error("Out-of-range word carries data.");

	a_quad: assert property (@(posedge clk) disable iff (!arst_n)
		valid && quad_valid |-> corner_a == vertex_index && corner_b == vertex_index + 16'd1)
		else $error("Quad corners do not match the vertex index.");

	a_noquad: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !quad_valid |-> corner_a == 16'd0 && corner_d == 16'd0)
		else $error("Corners set without a quad.");

endmodule

bind uv_sphere_vertex_generator_unit uvs_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.valid        (vtx.valid),
	.ready        (vtx.ready),
	.pos_x        (vtx.pos_x),
	.vertex_index (vtx.vertex_index),
	.quad_valid   (vtx.quad_valid),
	.corner_a     (vtx.corner_a),
	.corner_b     (vtx.corner_b),
	.corner_d     (vtx.corner_d),
	.out_of_range (vtx.out_of_range)
);
